// ===== sv/tvdi_pkg.sv =====
// Shared types and codes for the triangle vertex dedup indexer.
// No dependencies; imported by the top level and tvdi_normal.
package tvdi_pkg;

  typedef struct packed {
    logic        new_batch;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [1:0]  kind;
  } in_t;

  typedef struct packed {
    logic [23:0] a_index;
    logic [23:0] b_index;
    logic [23:0] c_index;
    logic        a_added;
    logic        b_added;
    logic        c_added;
    logic [3:0]  normal_bin;
    logic [1:0]  kind_out;
    logic        store_full;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pt_t;

  typedef struct packed {
    logic       done;
    logic [3:0] bin;
  } norm_t;

  localparam logic [1:0] KIND_FLOOR    = 2'd0;
  localparam logic [1:0] KIND_WALL     = 2'd1;
  localparam logic [1:0] KIND_ROOF     = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic [3:0] BIN_FLOOR = 4'd0;
  localparam logic [3:0] BIN_XPOS  = 4'd1;
  localparam logic [3:0] BIN_YPOS  = 4'd2;
  localparam logic [3:0] BIN_YNEG  = 4'd3;
  localparam logic [3:0] BIN_XNEG  = 4'd4;
  localparam logic [3:0] BIN_PP    = 4'd5;
  localparam logic [3:0] BIN_NN    = 4'd6;
  localparam logic [3:0] BIN_NP    = 4'd7;
  localparam logic [3:0] BIN_PN    = 4'd8;

endpackage

// ===== sv/triangle_vertex_dedup_indexer.sv =====
// Top level: triangle vertex dedup indexer with point store in one RAM.
// Depends on tvdi_pkg, tvdi_ram, tvdi_normal.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | in_data_i  (in_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (out_t)
//
// An item searches the stored points from the search start up to the point
// count: the search reads one stored point per cycle from the single RAM
// read port, then appends up to three points one per cycle.
// Reset clears the state, counters, batch base and valid flags only; no clearing pass.
// One item at a time; the result register lets a new beat in while the
// previous result is stalled.
module triangle_vertex_dedup_indexer import tvdi_pkg::*; #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned PW = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_APPEND = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]    state_q, state_d;
  in_t           in_q;
  logic [PW-1:0] pc_q, pc_d;
  logic [15:0]   tc_q, tc_d;
  logic [23:0]   base_q, base_d;
  logic [PW-1:0] j_q, j_d;
  logic          rdv_q, rdv_d;
  logic [PW-1:0] rdidx_q, rdidx_d;
  logic [2:0]    found_q, found_d;
  logic [PW-1:0] local_q [3];
  logic [PW-1:0] local_d [3];
  logic [2:0]    added_q, added_d;
  logic          full_q, full_d;
  logic [1:0]    k_q, k_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  logic          accept;
  logic [PW-1:0] pc_eff;
  logic [15:0]   tc_eff;
  logic [15:0]   half;
  logic [17:0]   start;
  pt_t           corner [3];
  pt_t           rd_pt;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  pt_t           wdata;
  norm_t         norm;
  logic [23:0]   idx [3];

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign corner[0] = '{x: in_q.ax, y: in_q.ay, z: in_q.az};
  assign corner[1] = '{x: in_q.bx, y: in_q.by, z: in_q.bz};
  assign corner[2] = '{x: in_q.cx, y: in_q.cy, z: in_q.cz};

  assign pc_eff = in_data_i.new_batch ? '0 : pc_q;
  assign tc_eff = in_data_i.new_batch ? '0 : tc_q;
  assign half   = 16'((17'(tc_eff) + 17'd1) >> 1);
  assign start  = (18'(half) << 1) + 18'(half);

  tvdi_ram #(.WIDTH($bits(pt_t)), .DEPTH(MAX_POINTS)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd_pt)
  );

  tvdi_normal u_normal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .pa_i    ('{x: in_data_i.ax, y: in_data_i.ay, z: in_data_i.az}),
    .pb_i    ('{x: in_data_i.bx, y: in_data_i.by, z: in_data_i.bz}),
    .pc_i    ('{x: in_data_i.cx, y: in_data_i.cy, z: in_data_i.cz}),
    .status_o(norm)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      idx[i] = (local_q[i] != '0) ? 24'(local_q[i]) + base_q : 24'd0;
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    tc_d        = tc_q;
    base_d      = base_q;
    j_d         = j_q;
    rdv_d       = 1'b0;
    rdidx_d     = rdidx_q;
    found_d     = found_q;
    local_d     = local_q;
    added_d     = added_q;
    full_d      = full_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = pc_q[AW-1:0];
    wdata       = corner[k_q];
    raddr       = j_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.new_batch) begin
            base_d = base_q + 24'(pc_q);
          end
          pc_d    = pc_eff;
          tc_d    = tc_eff;
          found_d = '0;
          added_d = '0;
          full_d  = 1'b0;
          k_d     = '0;
          for (int i = 0; i < 3; i++) begin
            local_d[i] = '0;
          end
          if ((pc_eff != '0) && (start < 18'(pc_eff))) begin
            j_d     = PW'(start);
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_APPEND;
          end
        end
      end
      ST_SEARCH: begin
        if (rdv_q) begin
          // last match wins; a takes precedence over b, b over c
          if (rd_pt == corner[0]) begin
            found_d[0] = 1'b1;
            local_d[0] = rdidx_q + 1'b1;
          end else if (rd_pt == corner[1]) begin
            found_d[1] = 1'b1;
            local_d[1] = rdidx_q + 1'b1;
          end else if (rd_pt == corner[2]) begin
            found_d[2] = 1'b1;
            local_d[2] = rdidx_q + 1'b1;
          end
        end
        if (j_q < pc_q) begin
          rdv_d   = 1'b1;
          rdidx_d = j_q;
          j_d     = j_q + 1'b1;
        end else if (!rdv_q) begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (!found_q[k_q]) begin
          if (pc_q < PW'(MAX_POINTS)) begin
            we              = 1'b1;
            pc_d            = pc_q + 1'b1;
            local_d[k_q]    = pc_q + 1'b1;
            added_d[k_q]    = 1'b1;
          end else begin
            full_d = 1'b1;
          end
        end
        if (k_q == 2'd2) begin
          if (tc_q != 16'hFFFF) begin
            tc_d = tc_q + 16'd1;
          end
          state_d = ST_FINISH;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_FINISH: begin
        if (norm.done && !(out_valid_q && out_stall_i)) begin
          out_d.a_index    = idx[0];
          out_d.b_index    = idx[1];
          out_d.c_index    = idx[2];
          out_d.a_added    = added_q[0];
          out_d.b_added    = added_q[1];
          out_d.c_added    = added_q[2];
          out_d.normal_bin = (in_q.kind == KIND_FLOOR) ? BIN_FLOOR : norm.bin;
          out_d.kind_out   = (in_q.kind == KIND_RESERVED) ? KIND_FLOOR : in_q.kind;
          out_d.store_full = full_q;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      tc_q        <= '0;
      base_q      <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      tc_q        <= tc_d;
      base_q      <= base_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    j_q     <= j_d;
    rdidx_q <= rdidx_d;
    found_q <= found_d;
    local_q <= local_d;
    added_q <= added_d;
    full_q  <= full_d;
    k_q     <= k_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_full_not_all_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.store_full && out_data_o.a_added &&
                      out_data_o.b_added && out_data_o.c_added))
    else $error("store full flagged while every corner was stored");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous item still in work");

  a_write_in_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_APPEND) && !found_q[k_q])
    else $error("store written outside append of an unmatched corner");
endmodule

// ===== sv/tvdi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tvdi_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  logic [WIDTH-1:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_i,
  output logic [WIDTH-1:0]               rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/tvdi_normal.sv =====
// Wall normal classifier: exact cross product x/y parts, eight-way bin.
// Six-stage pipeline, one multiplier per product. Depends on tvdi_pkg.
module tvdi_normal import tvdi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  pt_t   pa_i,
  input  pt_t   pb_i,
  input  pt_t   pc_i,
  output norm_t status_o
);
  logic [4:0] vld_q;
  logic       done_q;
  logic [3:0] bin_q, bin_d;

  logic signed [32:0] dx1_q, dy1_q, dz1_q, dx2_q, dy2_q, dz2_q;
  logic signed [65:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [66:0] xn_q, yn_q;
  logic [66:0] xa_q, ya_q;
  logic        xpos_q, ypos_q, yzero_q;
  logic [73:0] x1_q, y3_q, y33_q, x100_q;
  logic        xpos2_q, ypos2_q, yzero2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
      if (start_i) begin
        done_q <= 1'b0;
      end else if (vld_q[4]) begin
        done_q <= 1'b1;
      end
    end
  end

  always_comb begin
    bin_d = BIN_PN;
    if (yzero2_q || (x1_q > y3_q)) begin
      bin_d = xpos2_q ? BIN_XPOS : BIN_XNEG;
    end else if (y33_q > x100_q) begin
      bin_d = ypos2_q ? BIN_YPOS : BIN_YNEG;
    end else if (xpos2_q) begin
      bin_d = ypos2_q ? BIN_PP : BIN_PN;
    end else begin
      bin_d = ypos2_q ? BIN_NP : BIN_NN;
    end
  end

  always_ff @(posedge clk_i) begin
    dx1_q <= 33'(pb_i.x) - 33'(pa_i.x);
    dy1_q <= 33'(pb_i.y) - 33'(pa_i.y);
    dz1_q <= 33'(pb_i.z) - 33'(pa_i.z);
    dx2_q <= 33'(pc_i.x) - 33'(pa_i.x);
    dy2_q <= 33'(pc_i.y) - 33'(pa_i.y);
    dz2_q <= 33'(pc_i.z) - 33'(pa_i.z);

    p0_q <= 66'(dy1_q) * 66'(dz2_q);
    p1_q <= 66'(dz1_q) * 66'(dy2_q);
    p2_q <= 66'(dz1_q) * 66'(dx2_q);
    p3_q <= 66'(dx1_q) * 66'(dz2_q);

    xn_q <= 67'(p0_q) - 67'(p1_q);
    yn_q <= 67'(p2_q) - 67'(p3_q);

    xa_q    <= xn_q[66] ? 67'(-xn_q) : 67'(xn_q);
    ya_q    <= yn_q[66] ? 67'(-yn_q) : 67'(yn_q);
    xpos_q  <= !xn_q[66] && (xn_q != '0);
    ypos_q  <= !yn_q[66] && (yn_q != '0);
    yzero_q <= (yn_q == '0);

    x1_q     <= 74'(xa_q);
    y3_q     <= (74'(ya_q) << 1) + 74'(ya_q);
    y33_q    <= (74'(ya_q) << 5) + 74'(ya_q);
    x100_q   <= (74'(xa_q) << 6) + (74'(xa_q) << 5) + (74'(xa_q) << 2);
    xpos2_q  <= xpos_q;
    ypos2_q  <= ypos_q;
    yzero2_q <= yzero_q;

    if (vld_q[4]) begin
      bin_q <= bin_d;
    end
  end

  assign status_o.done = done_q;
  assign status_o.bin  = bin_q;
endmodule
